>>> src/sbsp_pkg.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser package
// Shared types and constants for the status packet parser.
// ----------------------------------------------------------------------------
package sbsp_pkg;

  localparam logic [7:0]  HeaderByte   = 8'hFF;
  localparam logic [7:0]  MaxParams    = 8'd32;
  localparam logic [7:0]  LenOverhead  = 8'd2;
  localparam logic [15:0] TimeoutReset = 16'd700;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdByte  = 2'd1,
    CmdTick  = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2
  } op_e;

  typedef enum logic {
    KindParam = 1'b0,
    KindEnd   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StChecksum = 2'd1,
    StLength   = 2'd2,
    StTimeout  = 2'd3
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic   full;
    logic   valid;
  } q_stat_t;

endpackage

>>> src/sbsp_if.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser channels
// Input word channel and result word channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sbsp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [7:0] node_id;
  logic [7:0] servo_error;
  logic [7:0] param_count;
  logic [7:0] param_index;
  logic [7:0] param_value;

  modport source (output valid, output kind, output status, output node_id,
                  output servo_error, output param_count, output param_index,
                  output param_value, input ready);
  modport sink   (input valid, input kind, input status, input node_id,
                  input servo_error, input param_count, input param_index,
                  input param_value, output ready);
endinterface

>>> src/sbsp_front.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser front end
// Accepts input words, decodes the command and hands operations to the queue.
// ----------------------------------------------------------------------------
module sbsp_front (
  sbsp_in_if.sink              rx_i,
  input  sbsp_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output sbsp_pkg::entry_t     push_entry_o
);
  import sbsp_pkg::*;

  cmd_e cmd;

  assign cmd        = cmd_e'(rx_i.command);
  assign rx_i.ready = !q_stat_i.full;

  // Unused command codes are accepted and dropped here.
  always_comb begin
    push_o            = 1'b0;
    push_entry_o.op   = OpStart;
    push_entry_o.data = rx_i.rx_byte;
    unique case (cmd)
      CmdStart: begin
        push_o          = rx_i.valid && !q_stat_i.full;
        push_entry_o.op = OpStart;
      end
      CmdByte: begin
        push_o          = rx_i.valid && !q_stat_i.full;
        push_entry_o.op = OpByte;
      end
      CmdTick: begin
        push_o          = rx_i.valid && !q_stat_i.full;
        push_entry_o.op = OpTick;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

>>> src/sbsp_queue.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser queue
// Two-entry queue of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module sbsp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sbsp_pkg::entry_t     push_entry_i,
  input  logic                 pop_i,
  output sbsp_pkg::entry_t     pop_entry_o,
  output sbsp_pkg::q_stat_t    q_stat_o
);
  import sbsp_pkg::*;

  entry_t     mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;

  assign q_stat_o.full  = (count_q == 2'd2);
  assign q_stat_o.valid = (count_q != 2'd0);
  assign pop_entry_o    = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

>>> src/sbsp_back.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser back end
// Runs the packet state machine, checks the checksum and registers results.
// ----------------------------------------------------------------------------
module sbsp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  sbsp_pkg::q_stat_t    q_stat_i,
  input  sbsp_pkg::entry_t     pop_entry_i,
  output logic                 pop_o,
  sbsp_out_if.source           res_o
);
  import sbsp_pkg::*;

  localparam logic [2:0] PhHdr1  = 3'd0;
  localparam logic [2:0] PhHdr2  = 3'd1;
  localparam logic [2:0] PhId    = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhErr   = 3'd4;
  localparam logic [2:0] PhParam = 3'd5;
  localparam logic [2:0] PhSum   = 3'd6;

  logic        armed_q, armed_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] ticks_q, ticks_d;
  logic [15:0] limit_q;

  logic        emit;
  kind_e       emit_kind;
  status_e     emit_status;
  logic [7:0]  emit_index;
  logic [7:0]  emit_value;
  logic [7:0]  len_cnt;
  logic [15:0] ticks_inc;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_id_q, out_err_q, out_cnt_q, out_index_q, out_value_q;

  logic [7:0]  b;

  assign b         = pop_entry_i.data;
  assign pop_o     = q_stat_i.valid && (!out_valid_q || res_o.ready);
  assign len_cnt   = b - LenOverhead;
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

  always_comb begin
    armed_d     = armed_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    sum_d       = sum_q;
    ticks_d     = ticks_q;
    emit        = 1'b0;
    emit_kind   = KindEnd;
    emit_status = StOk;
    emit_index  = 8'd0;
    emit_value  = 8'd0;
    if (pop_o) begin
      unique case (pop_entry_i.op)
        OpStart: begin
          armed_d = 1'b1;
          phase_d = PhHdr1;
          pos_d   = 8'd0;
          id_d    = 8'd0;
          cnt_d   = 8'd0;
          err_d   = 8'd0;
          sum_d   = 8'd0;
          ticks_d = 16'd0;
        end
        OpTick: begin
          if (armed_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc > limit_q) begin
              emit        = 1'b1;
              emit_status = StTimeout;
              armed_d     = 1'b0;
              phase_d     = PhHdr1;
            end
          end
        end
        OpByte: begin
          if (armed_q) begin
            ticks_d = 16'd0;
            unique case (phase_q)
              PhHdr1: begin
                if (b == HeaderByte) begin
                  phase_d = PhHdr2;
                end
              end
              PhHdr2: begin
                phase_d = (b == HeaderByte) ? PhId : PhHdr1;
              end
              PhId: begin
                id_d    = b;
                sum_d   = b;
                phase_d = PhLen;
              end
              PhLen: begin
                if (len_cnt > MaxParams) begin
                  cnt_d       = 8'd0;
                  emit        = 1'b1;
                  emit_status = StLength;
                  armed_d     = 1'b0;
                  phase_d     = PhHdr1;
                end else begin
                  cnt_d   = len_cnt;
                  sum_d   = sum_q + b;
                  phase_d = PhErr;
                end
              end
              PhErr: begin
                err_d   = b;
                sum_d   = sum_q + b;
                pos_d   = 8'd0;
                phase_d = (cnt_q == 8'd0) ? PhSum : PhParam;
              end
              PhParam: begin
                sum_d      = sum_q + b;
                pos_d      = pos_q + 8'd1;
                if ((pos_q + 8'd1) >= cnt_q) begin
                  phase_d = PhSum;
                end
                emit       = 1'b1;
                emit_kind  = KindParam;
                emit_index = pos_q;
                emit_value = b;
              end
              PhSum: begin
                emit        = 1'b1;
                emit_status = (~sum_q == b) ? StOk : StChecksum;
                armed_d     = 1'b0;
                phase_d     = PhHdr1;
              end
              default: begin
                phase_d = PhHdr1;
              end
            endcase
          end
        end
        default: begin
          armed_d = armed_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      phase_q     <= PhHdr1;
      pos_q       <= 8'd0;
      id_q        <= 8'd0;
      cnt_q       <= 8'd0;
      err_q       <= 8'd0;
      sum_q       <= 8'd0;
      ticks_q     <= 16'd0;
      limit_q     <= TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      id_q        <= id_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      sum_q       <= sum_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_kind_q   <= emit_kind;
      out_status_q <= emit_status;
      out_id_q     <= id_d;
      out_err_q    <= err_d;
      out_cnt_q    <= cnt_d;
      out_index_q  <= emit_index;
      out_value_q  <= emit_value;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.status      = out_status_q;
  assign res_o.node_id     = out_id_q;
  assign res_o.servo_error = out_err_q;
  assign res_o.param_count = out_cnt_q;
  assign res_o.param_index = out_index_q;
  assign res_o.param_value = out_value_q;

endmodule

>>> src/servo_bus_status_packet_parser.sv
// ----------------------------------------------------------------------------
// Servo bus status packet parser
// Parses status packets byte by byte and reports parameters and end status.
// ----------------------------------------------------------------------------
// The parser takes one input word per clock cycle while the queue is not
// full. A decoder feeds a two-word queue, and the packet state machine
// behind it handles one word per cycle, so the sustained rate is one word
// per cycle as long as results are taken. An accepted word is written into
// the queue, and its result is then registered in an output register. The
// timeout limit register may be written only while no word is in flight.
module servo_bus_status_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  sbsp_in_if.sink     rx_i,
  sbsp_out_if.source  res_o
);
  import sbsp_pkg::*;

  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  pop_entry;
  q_stat_t q_stat;

  sbsp_front u_front (
    .rx_i         (rx_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  sbsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .q_stat_o     (q_stat)
  );

  sbsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

>>> test/tb_servo_bus_status_packet_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the servo bus status packet parser
// Drives command words through the input channel and checks every result
// word against a cycle-free model of the parser kept in this file. A short
// table of directed words comes first, then random status packets under
// several timeout limits, with random idling on both channels and a long
// result hold-off that backs the parser up into its input.
// ----------------------------------------------------------------------------
module tb_servo_bus_status_packet_parser;
  import sbsp_pkg::*;

  typedef enum logic [2:0] {
    PhHdr1, PhHdr2, PhId, PhLen, PhErr, PhParam, PhSum
  } rx_phase_e;

  typedef struct packed {
    kind_e      kind;
    status_e    status;
    logic [7:0] node_id;
    logic [7:0] servo_error;
    logic [7:0] param_count;
    logic [7:0] param_index;
    logic [7:0] param_value;
  } result_t;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
    bit         typed;
    result_t    res;
  } step_row_t;

  localparam int DirectedRows = 25;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sbsp_in_if  rx_if ();
  sbsp_out_if res_if ();

  servo_bus_status_packet_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // Parser state as the checker sees it.
  logic [15:0] p_limit = TimeoutReset;
  bit          p_armed = 1'b0;
  rx_phase_e   p_phase = PhHdr1;
  logic [7:0]  p_pos   = '0;
  logic [7:0]  p_id    = '0;
  logic [7:0]  p_count = '0;
  logic [7:0]  p_err   = '0;
  logic [7:0]  p_sum   = '0;
  logic [15:0] p_idle  = '0;

  result_t pending_results[$];
  int      mismatches    = 0;
  int      words_sent    = 0;
  int      results_taken = 0;
  int      next_hold_at  = 30;
  int      hold_left     = 0;
  bit      steady        = 1'b0;

  step_row_t directed_rows [DirectedRows] = '{
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdTick,  8'h00, 1'b0, '0},
    '{CmdStart, 8'h00, 1'b0, '0},
    '{CmdNop,   8'hA5, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'h00, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'h01, 1'b0, '0},
    '{CmdByte,  8'h01, 1'b1, '{KindEnd, StLength, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{CmdStart, 8'hFF, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'hFE, 1'b0, '0},
    '{CmdByte,  8'h02, 1'b0, '0},
    '{CmdByte,  8'h80, 1'b0, '0},
    '{CmdByte,  8'h7F, 1'b1, '{KindEnd, StOk, 8'hFE, 8'h80, 8'h00, 8'h00, 8'h00}},
    '{CmdStart, 8'h5A, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'h00, 1'b0, '0},
    '{CmdByte,  8'h03, 1'b0, '0},
    '{CmdByte,  8'hFF, 1'b0, '0},
    '{CmdByte,  8'h5A, 1'b0, '0},
    '{CmdByte,  8'h00, 1'b1, '{KindEnd, StChecksum, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00}}
  };

  function automatic result_t end_word(input status_e st);
    end_word = '{KindEnd, st, p_id, p_err, p_count, 8'h00, 8'h00};
    p_armed = 1'b0;
    p_phase = PhHdr1;
  endfunction

  function automatic bit predict_word(input cmd_e cmd, input logic [7:0] data,
                                      output result_t res);
    logic [7:0] cnt;
    logic [7:0] good_sum;
    bit         emitted;
    emitted = 1'b0;
    res = '0;
    if (cmd == CmdStart) begin
      p_armed = 1'b1;
      p_phase = PhHdr1;
      p_pos   = '0;
      p_id    = '0;
      p_count = '0;
      p_err   = '0;
      p_sum   = '0;
      p_idle  = '0;
    end else if (p_armed && cmd == CmdTick) begin
      if (p_idle != 16'hFFFF) p_idle = p_idle + 16'd1;
      if (p_idle > p_limit) begin
        res = end_word(StTimeout);
        emitted = 1'b1;
      end
    end else if (p_armed && cmd == CmdByte) begin
      p_idle = '0;
      case (p_phase)
        PhHdr1: if (data == HeaderByte) p_phase = PhHdr2;
        PhHdr2: p_phase = (data == HeaderByte) ? PhId : PhHdr1;
        PhId: begin
          p_id = data;
          p_sum = data;
          p_phase = PhLen;
        end
        PhLen: begin
          cnt = data - LenOverhead;
          if (cnt > MaxParams) begin
            p_count = '0;
            res = end_word(StLength);
            emitted = 1'b1;
          end else begin
            p_count = cnt;
            p_sum = p_sum + data;
            p_phase = PhErr;
          end
        end
        PhErr: begin
          p_err = data;
          p_sum = p_sum + data;
          p_pos = '0;
          p_phase = (p_count == 8'd0) ? PhSum : PhParam;
        end
        PhParam: begin
          res = '{KindParam, StOk, p_id, p_err, p_count, p_pos, data};
          emitted = 1'b1;
          p_sum = p_sum + data;
          p_pos = p_pos + 8'd1;
          if (p_pos >= p_count) p_phase = PhSum;
        end
        default: begin
          good_sum = ~p_sum;
          res = end_word((good_sum == data) ? StOk : StChecksum);
          emitted = 1'b1;
        end
      endcase
    end
    return emitted;
  endfunction

  task automatic flag_mismatch(input string what, input result_t want,
                               input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d status %0d id %h error %h count %0d index %0d value %h",
               what, want.kind, want.status, want.node_id, want.servo_error,
               want.param_count, want.param_index, want.param_value);
      $display("  got kind %0d status %0d id %h error %h count %0d index %0d value %h",
               got.kind, got.status, got.node_id, got.servo_error,
               got.param_count, got.param_index, got.param_value);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("unexpected result", '0, got);
    end else begin
      want = pending_results.pop_front();
      if (got.kind != want.kind || got.status != want.status ||
          got.node_id != want.node_id || got.servo_error != want.servo_error ||
          got.param_count != want.param_count || got.param_index != want.param_index ||
          got.param_value != want.param_value) begin
        flag_mismatch("result mismatch", want, got);
      end
    end
  endtask

  task automatic send_word(input cmd_e cmd, input logic [7:0] data,
                           input bit typed = 1'b0, input result_t given = '0);
    result_t res;
    bit      emitted;
    if (!steady && $urandom_range(99) < 30) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
      while (!steady && $urandom_range(99) < 30) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.command <= cmd;
    rx_if.rx_byte <= data;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    words_sent++;
    emitted = predict_word(cmd, data, res);
    if (typed) begin
      pending_results.push_back(given);
    end else if (emitted) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic drain_results();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_limit = value;
  endtask

  task automatic tick_burst();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 7)) send_word(CmdTick, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_packet();
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] val;
    logic [7:0] sum;
    logic [7:0] chk;
    int         cnt;
    int         roll;
    if ($urandom_range(99) < 92) send_word(CmdStart, 8'($urandom_range(0, 255)));
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) send_word(CmdByte, 8'($urandom_range(0, 254)));
    end
    if ($urandom_range(99) < 5) send_word(CmdNop, 8'($urandom_range(0, 255)));
    send_word(CmdByte, HeaderByte);
    tick_burst();
    if ($urandom_range(99) < 5) send_word(CmdByte, 8'($urandom_range(0, 254)));
    send_word(CmdByte, HeaderByte);
    id  = 8'($urandom_range(0, 255));
    err = 8'($urandom_range(0, 255));
    roll = $urandom_range(99);
    if (roll < 10) cnt = 0;
    else if (roll < 20) cnt = int'(MaxParams);
    else if (roll < 26) cnt = -1;
    else cnt = $urandom_range(1, 6);
    if (cnt < 0) begin
      roll = $urandom_range(2);
      len = (roll == 2) ? 8'($urandom_range(int'(MaxParams) + 3, 255)) : 8'(roll);
    end else begin
      len = 8'(cnt) + LenOverhead;
    end
    send_word(CmdByte, id);
    tick_burst();
    send_word(CmdByte, len);
    if (cnt < 0) return;
    send_word(CmdByte, err);
    sum = id + len + err;
    for (int i = 0; i < cnt; i++) begin
      val = 8'($urandom_range(0, 255));
      sum = sum + val;
      send_word(CmdByte, val);
      tick_burst();
      if ($urandom_range(99) < 2) begin
        send_word(CmdStart, 8'($urandom_range(0, 255)));
        return;
      end
    end
    chk = ~sum;
    if ($urandom_range(99) < 15) chk = chk ^ 8'($urandom_range(1, 255));
    send_word(CmdByte, chk);
  endtask

  task automatic run_packets(input int n_words);
    int first;
    first = words_sent;
    while (words_sent - first < n_words) send_packet();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_result('{kind_e'(res_if.kind), status_e'(res_if.status), res_if.node_id,
                       res_if.servo_error, res_if.param_count, res_if.param_index,
                       res_if.param_value});
        results_taken++;
      end
      if (!steady && hold_left == 0 && results_taken >= next_hold_at) begin
        hold_left = 300;
        next_hold_at = next_hold_at + 270;
      end
      if (!steady && hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.command <= CmdNop;
    rx_if.rx_byte <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedRows; i++) begin
      send_word(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].res);
    end

    set_timeout(16'd5);
    run_packets(180);

    set_timeout(16'd0);
    steady = 1'b1;
    run_packets(150);
    steady = 1'b0;

    set_timeout(16'hFFFF);
    send_word(CmdStart, 8'h00);
    send_word(CmdByte, HeaderByte);
    send_word(CmdByte, HeaderByte);
    send_word(CmdByte, 8'h12);
    send_word(CmdByte, 8'h02);
    send_word(CmdByte, 8'h00);
    repeat (20) send_word(CmdTick, 8'($urandom_range(0, 255)));
    send_word(CmdByte, 8'hEB);
    run_packets(120);

    set_timeout(16'($urandom_range(1, 30)));
    run_packets(150);

    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/sbsp_pkg.sv
src/sbsp_if.sv
src/sbsp_front.sv
src/sbsp_queue.sv
src/sbsp_back.sv
src/servo_bus_status_packet_parser.sv
test/tb_servo_bus_status_packet_parser.sv
